// File: rtl/assert_macros.svh
// Assertion macros for the RTL of the soft disk stamp block.
// Define NO_ASSERTIONS to compile every assertion away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SDS_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("assertion failed");
`define SDS_ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
	else $error("forbidden condition seen");
`else
`define SDS_ASSERT(lbl, clk, rst_n, prop)
`define SDS_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

// File: rtl/sds_pkg.sv
// Shared constants and types of the soft disk stamp block.
// No dependencies; used by the top level, sds_root and the testbench.
package sds_pkg;

	localparam int MAP_SIZE = 256;
	localparam int DEPTH    = MAP_SIZE * MAP_SIZE;
	localparam int CW       = $clog2(MAP_SIZE);
	localparam int AW       = $clog2(DEPTH);
	localparam int PIX_W    = 8;

	// texel-space position widths (Q.8)
	localparam int TW = 44;
	localparam int PW = 46;
	localparam int RTW = 39;
	localparam int TX_OFFSET = MAP_SIZE * 128;

	// stamp: v = largest n with (n + STAMP_BASE) * r <= 850 * d
	localparam int STAMP_K    = 722500;
	localparam int STAMP_BASE = 595;
	localparam int RS_W       = 20;
	localparam int RAD_W      = 62;
	localparam int ROOT_W     = 31;
	localparam int QUOT_W     = 10;

	localparam int CFG_IW = 2;

	typedef enum logic [CFG_IW-1:0] {
		REG_ORIGIN_X = 2'd0,
		REG_ORIGIN_Y = 2'd1,
		REG_TEXELS   = 2'd2
	} reg_index_t;

	typedef struct packed {
		logic              start;
		logic [RAD_W-1:0]  rad;
		logic [RS_W-1:0]   rs;
	} root_req_t;

	typedef struct packed {
		logic              done;
		logic [PIX_W-1:0]  v;
	} root_resp_t;

endpackage

// File: rtl/soft_disk_min_stamp.sv
// Top level of the soft disk stamp block: sequencer, registers and coverage map.
// Depends on sds_pkg, sds_ram, sds_mul, sds_root and assert_macros.svh.
//
// After reset the block clears its 65536-texel map to 255, one texel a cycle, and holds busy
// high until the sweep ends. An item is taken when start is high and busy is low; done marks
// its result for one cycle and cannot be held off. A read passes through ST_RD1 and ST_RD2,
// and its result shows with done as busy falls. A reveal forms three products through the
// shared multiplier (each in ST_M0 to ST_M4), then the box, a normalize step per bit the
// radius is shifted down (up to 19 bits) and the radius square. It then walks the clamped box:
// a texel outside the bounding square of the disk ends after ST_PIX, one inside the square but
// outside the disk after the distance square, and one inside the disk waits for the square
// root and divide unit (one bit a cycle). The result shows in the cycle after the last texel.
`include "assert_macros.svh"
module soft_disk_min_stamp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	output logic                        done,
	input  logic                        cfg_we,
	input  logic [sds_pkg::CFG_IW-1:0]  cfg_index,
	input  logic [31:0]                 cfg_data,
	input  logic                        action,
	input  logic signed [31:0]          center_x,
	input  logic signed [31:0]          center_y,
	input  logic [30:0]                 world_radius,
	input  logic [7:0]                  read_x,
	input  logic [7:0]                  read_y,
	output logic                        changed,
	output logic [7:0]                  box_x,
	output logic [7:0]                  box_y,
	output logic [8:0]                  box_width,
	output logic [8:0]                  box_height,
	output logic [7:0]                  pixel_value
);

	typedef enum logic [22:0] {
		ST_CLEAR = 23'h000001,
		ST_IDLE  = 23'h000002,
		ST_RD1   = 23'h000004,
		ST_RD2   = 23'h000008,
		ST_M0    = 23'h000010,
		ST_M1    = 23'h000020,
		ST_M2    = 23'h000040,
		ST_M3    = 23'h000080,
		ST_M4    = 23'h000100,
		ST_BOX   = 23'h000200,
		ST_NORM  = 23'h000400,
		ST_RS0   = 23'h000800,
		ST_RS1   = 23'h001000,
		ST_PIX   = 23'h002000,
		ST_SQ0   = 23'h004000,
		ST_SQ1   = 23'h008000,
		ST_SQ2   = 23'h010000,
		ST_DM0   = 23'h020000,
		ST_DM1   = 23'h040000,
		ST_DM2   = 23'h080000,
		ST_DM3   = 23'h100000,
		ST_ROOT  = 23'h200000,
		ST_NEXT  = 23'h400000
	} state_t;

	typedef enum logic [1:0] {
		JOB_TX = 2'd0,
		JOB_TY = 2'd1,
		JOB_RT = 2'd2
	} job_t;

	state_t state_q;
	job_t   job_q;
	logic   done_q;
	logic [sds_pkg::AW-1:0] clr_q;

	logic signed [31:0] origin_x_q, origin_y_q;
	logic [23:0]        tpu_q;

	logic signed [32:0]            dxw_q, dyw_q;
	logic [30:0]                   rad_q;
	logic [63:0]                   acc_q;
	logic signed [sds_pkg::TW-1:0] tx_q, ty_q;
	logic [sds_pkg::RTW-1:0]       rt_q, rs_q;
	logic [4:0]                    k_q;
	logic [39:0]                   rs2_q;
	logic [sds_pkg::CW-1:0]        x0_q, x1_q, y0_q, y1_q, x_q, y_q;
	logic [sds_pkg::RS_W-1:0]      axs_q, ays_q;
	logic [40:0]                   dd_q;
	logic [sds_pkg::AW-1:0]        addr_q;
	logic                          dirty_q, rd_ok_q;

	logic                          changed_q;
	logic [7:0]                    box_x_q, box_y_q, pixel_value_q;
	logic [8:0]                    box_width_q, box_height_q;

	logic [32:0] op_mag;
	logic        op_neg;
	logic [23:0] mul_a, mul_b;
	logic [47:0] mul_p;
	logic [41:0] t_sh;

	logic signed [sds_pkg::PW-1:0] px, py, dx, dy, lo_x, hi_x, lo_y, hi_y;
	logic [sds_pkg::PW-1:0]        ax, ay, ax_sh, ay_sh;
	logic                          miss;
	logic [40:0]                   dd_sum;
	logic [sds_pkg::CW:0]          wid_x, wid_y;

	logic                         ram_we;
	logic [sds_pkg::AW-1:0]       ram_waddr;
	logic [sds_pkg::PIX_W-1:0]    ram_wdata, ram_rdata;
	sds_pkg::root_req_t           root_req;
	sds_pkg::root_resp_t          root_resp;

	function automatic logic [sds_pkg::CW-1:0] clamp_cell(
		input logic signed [sds_pkg::PW-1:0] v
	);
		logic signed [sds_pkg::PW-1:0] q;
		q = v >>> 8;
		if (v < 0) begin
			return '0;
		end else if (q > $signed(sds_pkg::PW'(sds_pkg::MAP_SIZE - 1))) begin
			return sds_pkg::CW'(sds_pkg::MAP_SIZE - 1);
		end else begin
			return q[sds_pkg::CW-1:0];
		end
	endfunction

	// operand of the current scale product
	always_comb begin
		case (job_q)
			JOB_TX: begin
				op_neg = dxw_q[32];
				op_mag = op_neg ? $unsigned(-dxw_q) : $unsigned(dxw_q);
			end
			JOB_TY: begin
				op_neg = dyw_q[32];
				op_mag = op_neg ? $unsigned(-dyw_q) : $unsigned(dyw_q);
			end
			default: begin
				op_neg = 1'b0;
				op_mag = 33'(rad_q);
			end
		endcase
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_M0: begin
				mul_a = op_mag[23:0];
				mul_b = tpu_q;
			end
			ST_M1: begin
				mul_a = 24'(op_mag[32:24]);
				mul_b = tpu_q;
			end
			ST_RS0: begin
				mul_a = 24'(rs_q[sds_pkg::RS_W-1:0]);
				mul_b = 24'(rs_q[sds_pkg::RS_W-1:0]);
			end
			ST_SQ0: begin
				mul_a = 24'(axs_q);
				mul_b = 24'(axs_q);
			end
			ST_SQ1: begin
				mul_a = 24'(ays_q);
				mul_b = 24'(ays_q);
			end
			ST_DM0: begin
				mul_a = dd_q[23:0];
				mul_b = 24'(sds_pkg::STAMP_K);
			end
			ST_DM1: begin
				mul_a = 24'(dd_q[40:24]);
				mul_b = 24'(sds_pkg::STAMP_K);
			end
			default: begin
				mul_a = '0;
			end
		endcase
	end

	always_comb begin
		t_sh  = acc_q[57:16];
		px    = $signed({{(sds_pkg::PW - sds_pkg::CW - 8){1'b0}}, x_q, 8'h00});
		py    = $signed({{(sds_pkg::PW - sds_pkg::CW - 8){1'b0}}, y_q, 8'h00});
		dx    = px - sds_pkg::PW'(tx_q);
		dy    = py - sds_pkg::PW'(ty_q);
		ax    = dx[sds_pkg::PW-1] ? $unsigned(-dx) : $unsigned(dx);
		ay    = dy[sds_pkg::PW-1] ? $unsigned(-dy) : $unsigned(dy);
		ax_sh = ax >> k_q;
		ay_sh = ay >> k_q;
		miss  = (ax >= sds_pkg::PW'(rt_q)) || (ay >= sds_pkg::PW'(rt_q));
		lo_x  = sds_pkg::PW'(tx_q) - $signed(sds_pkg::PW'(rt_q));
		hi_x  = sds_pkg::PW'(tx_q) + $signed(sds_pkg::PW'(rt_q));
		lo_y  = sds_pkg::PW'(ty_q) - $signed(sds_pkg::PW'(rt_q));
		hi_y  = sds_pkg::PW'(ty_q) + $signed(sds_pkg::PW'(rt_q));
		dd_sum = 41'(acc_q[39:0]) + 41'(mul_p[39:0]);
		wid_x = (sds_pkg::CW+1)'(x1_q) - (sds_pkg::CW+1)'(x0_q) + 1'b1;
		wid_y = (sds_pkg::CW+1)'(y1_q) - (sds_pkg::CW+1)'(y0_q) + 1'b1;
	end

	// map write port: clearing sweep or a lowered texel
	always_comb begin
		ram_we    = (state_q == ST_CLEAR)
			|| ((state_q == ST_ROOT) && root_resp.done && (root_resp.v < ram_rdata));
		ram_waddr = (state_q == ST_CLEAR) ? clr_q : addr_q;
		ram_wdata = (state_q == ST_CLEAR) ? {sds_pkg::PIX_W{1'b1}} : root_resp.v;
	end

	always_comb begin
		root_req.start = (state_q == ST_DM3);
		root_req.rad   = acc_q[sds_pkg::RAD_W-1:0];
		root_req.rs    = rs_q[sds_pkg::RS_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= '0;
			origin_y_q <= '0;
			tpu_q      <= 24'd16777;
		end else if (cfg_we) begin
			case (cfg_index)
				sds_pkg::REG_ORIGIN_X: origin_x_q <= $signed(cfg_data);
				sds_pkg::REG_ORIGIN_Y: origin_y_q <= $signed(cfg_data);
				sds_pkg::REG_TEXELS:   tpu_q      <= cfg_data[23:0];
				default:               tpu_q      <= tpu_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			job_q   <= JOB_TX;
			done_q  <= 1'b0;
			clr_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == sds_pkg::AW'(sds_pkg::DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						job_q   <= JOB_TX;
						state_q <= action ? ST_RD1 : ST_M0;
					end
				end
				ST_RD1: state_q <= ST_RD2;
				ST_RD2: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_M0: state_q <= ST_M1;
				ST_M1: state_q <= ST_M2;
				ST_M2: state_q <= ST_M3;
				ST_M3: state_q <= ST_M4;
				ST_M4: begin
					case (job_q)
						JOB_TX: begin
							job_q   <= JOB_TY;
							state_q <= ST_M0;
						end
						JOB_TY: begin
							job_q   <= JOB_RT;
							state_q <= ST_M0;
						end
						default: state_q <= ST_BOX;
					endcase
				end
				ST_BOX: state_q <= ST_NORM;
				ST_NORM: begin
					if (rs_q[sds_pkg::RTW-1:sds_pkg::RS_W] == '0) begin
						state_q <= ST_RS0;
					end
				end
				ST_RS0: state_q <= ST_RS1;
				ST_RS1: state_q <= ST_PIX;
				ST_PIX: state_q <= miss ? ST_NEXT : ST_SQ0;
				ST_SQ0: state_q <= ST_SQ1;
				ST_SQ1: state_q <= ST_SQ2;
				ST_SQ2: state_q <= ({1'b0, dd_sum} >= 42'(rs2_q)) ? ST_NEXT : ST_DM0;
				ST_DM0: state_q <= ST_DM1;
				ST_DM1: state_q <= ST_DM2;
				ST_DM2: state_q <= ST_DM3;
				ST_DM3: state_q <= ST_ROOT;
				ST_ROOT: begin
					if (root_resp.done) begin
						state_q <= ST_NEXT;
					end
				end
				ST_NEXT: begin
					if ((y_q == y1_q) && (x_q == x1_q)) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_PIX;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				addr_q  <= sds_pkg::AW'(read_y) * sds_pkg::AW'(sds_pkg::MAP_SIZE)
					+ sds_pkg::AW'(read_x);
				rd_ok_q <= (11'(read_x) < 11'(sds_pkg::MAP_SIZE))
					&& (11'(read_y) < 11'(sds_pkg::MAP_SIZE));
				dxw_q   <= 33'(center_x) - 33'(origin_x_q);
				dyw_q   <= 33'(center_y) - 33'(origin_y_q);
				rad_q   <= world_radius;
				dirty_q <= 1'b0;
			end
			ST_RD2: begin
				changed_q     <= 1'b0;
				box_x_q       <= '0;
				box_y_q       <= '0;
				box_width_q   <= '0;
				box_height_q  <= '0;
				pixel_value_q <= rd_ok_q ? ram_rdata : 8'hFF;
			end
			ST_M1: acc_q <= 64'(mul_p);
			ST_M2: acc_q <= acc_q + 64'({mul_p, 24'h000000});
			ST_M3: begin
				// round toward minus infinity for a negative offset
				if (op_neg) begin
					acc_q <= acc_q + 64'd65535;
				end
			end
			ST_M4: begin
				case (job_q)
					JOB_TX: tx_q <= op_neg
						? sds_pkg::TW'(sds_pkg::TX_OFFSET) - sds_pkg::TW'(t_sh)
						: sds_pkg::TW'(sds_pkg::TX_OFFSET) + sds_pkg::TW'(t_sh);
					JOB_TY: ty_q <= op_neg
						? sds_pkg::TW'(sds_pkg::TX_OFFSET) - sds_pkg::TW'(t_sh)
						: sds_pkg::TW'(sds_pkg::TX_OFFSET) + sds_pkg::TW'(t_sh);
					default: rt_q <= t_sh[sds_pkg::RTW-1:0];
				endcase
			end
			ST_BOX: begin
				x0_q <= clamp_cell(lo_x);
				x1_q <= clamp_cell(hi_x);
				y0_q <= clamp_cell(lo_y);
				y1_q <= clamp_cell(hi_y);
				rs_q <= rt_q;
				k_q  <= '0;
			end
			ST_NORM: begin
				// shift a huge radius down below 2^20
				if (rs_q[sds_pkg::RTW-1:sds_pkg::RS_W] != '0) begin
					rs_q <= rs_q >> 1;
					k_q  <= k_q + 5'd1;
				end
			end
			ST_RS1: begin
				rs2_q <= mul_p[39:0];
				x_q   <= x0_q;
				y_q   <= y0_q;
			end
			ST_PIX: begin
				axs_q  <= ax_sh[sds_pkg::RS_W-1:0];
				ays_q  <= ay_sh[sds_pkg::RS_W-1:0];
				addr_q <= sds_pkg::AW'(y_q) * sds_pkg::AW'(sds_pkg::MAP_SIZE)
					+ sds_pkg::AW'(x_q);
			end
			ST_SQ1: acc_q <= 64'(mul_p);
			ST_SQ2: dd_q <= dd_sum;
			ST_DM1: acc_q <= 64'(mul_p);
			ST_DM2: acc_q <= acc_q + 64'({mul_p, 24'h000000});
			ST_ROOT: begin
				if (root_resp.done && (root_resp.v < ram_rdata)) begin
					dirty_q <= 1'b1;
				end
			end
			ST_NEXT: begin
				if (y_q == y1_q) begin
					y_q <= y0_q;
					x_q <= sds_pkg::CW'(x_q + 1'b1);
				end else begin
					y_q <= sds_pkg::CW'(y_q + 1'b1);
				end
				if ((y_q == y1_q) && (x_q == x1_q)) begin
					changed_q     <= dirty_q;
					box_x_q       <= dirty_q ? 8'(x0_q) : '0;
					box_y_q       <= dirty_q ? 8'(y0_q) : '0;
					box_width_q   <= dirty_q ? 9'(wid_x) : '0;
					box_height_q  <= dirty_q ? 9'(wid_y) : '0;
					pixel_value_q <= '0;
				end
			end
			default: begin
				rd_ok_q <= rd_ok_q;
			end
		endcase
	end

	sds_ram #(
		.WIDTH(sds_pkg::PIX_W),
		.DEPTH(sds_pkg::DEPTH)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (addr_q),
		.rdata (ram_rdata)
	);

	sds_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	sds_root u_root (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (root_req),
		.resp   (root_resp)
	);

	assign busy        = (state_q != ST_IDLE);
	assign done        = done_q;
	assign changed     = changed_q;
	assign box_x       = box_x_q;
	assign box_y       = box_y_q;
	assign box_width   = box_width_q;
	assign box_height  = box_height_q;
	assign pixel_value = pixel_value_q;

	`SDS_ASSERT(a_done_after_work, clk, arst_n, done |-> $past(busy))
	`SDS_ASSERT(a_accept_goes_busy, clk, arst_n, (start && !busy) |=> busy)
	`SDS_ASSERT(a_changed_has_box, clk, arst_n, (done && changed) |-> (|box_width && |box_height))
	`SDS_ASSERT_NEVER(a_no_idle_write, clk, arst_n, ram_we && (state_q == ST_IDLE))

endmodule

// File: rtl/sds_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sds_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/sds_mul.sv
// Shared 24x24 unsigned multiplier with a registered product.
// Depends on nothing; the sequencer in the top level feeds it.
module sds_mul (
	input  logic        clk,
	input  logic [23:0] a,
	input  logic [23:0] b,
	output logic [47:0] p
);

	always_ff @(posedge clk) begin
		p <= a * b;
	end

endmodule

// File: rtl/sds_root.sv
// Bit-serial square root followed by a short restoring divide; yields one stamp value.
// Depends on sds_pkg.
module sds_root (
	input  logic               clk,
	input  logic               arst_n,
	input  sds_pkg::root_req_t req,
	output sds_pkg::root_resp_t resp
);

	typedef enum logic [2:0] {
		R_IDLE = 3'b001,
		R_SQRT = 3'b010,
		R_DIV  = 3'b100
	} rstate_t;

	rstate_t state_q;
	logic    done_q;

	logic [sds_pkg::RAD_W-1:0]  dq_q;
	logic [33:0]                rem_q;
	logic [sds_pkg::ROOT_W-1:0] root_q;
	logic [sds_pkg::ROOT_W-1:0] s_q;
	logic [sds_pkg::RS_W-1:0]   rs_q;
	logic [sds_pkg::QUOT_W-1:0] q_q;
	logic [4:0]                 cnt_q;
	logic [sds_pkg::PIX_W-1:0]  v_q;

	logic [33:0]                rem_sh, trial, rem_n;
	logic                       ge;
	logic [sds_pkg::ROOT_W-1:0] root_n;
	logic [sds_pkg::ROOT_W-1:0] dv, s_n;
	logic                       ge_d;
	logic [sds_pkg::QUOT_W-1:0] q_n;
	logic [sds_pkg::PIX_W-1:0]  v_n;

	always_comb begin
		rem_sh = {rem_q[31:0], dq_q[sds_pkg::RAD_W-1 -: 2]};
		trial  = {1'b0, root_q, 2'b01};
		ge     = rem_sh >= trial;
		rem_n  = ge ? rem_sh - trial : rem_sh;
		root_n = {root_q[sds_pkg::ROOT_W-2:0], ge};

		dv   = sds_pkg::ROOT_W'(rs_q) << cnt_q;
		ge_d = s_q >= dv;
		s_n  = ge_d ? s_q - dv : s_q;
		q_n  = {q_q[sds_pkg::QUOT_W-2:0], ge_d};
		v_n  = (q_n >= sds_pkg::QUOT_W'(sds_pkg::STAMP_BASE))
			? sds_pkg::PIX_W'(q_n - sds_pkg::QUOT_W'(sds_pkg::STAMP_BASE)) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= R_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				R_IDLE: begin
					if (req.start) begin
						state_q <= R_SQRT;
					end
				end
				R_SQRT: begin
					if (cnt_q == 5'(sds_pkg::ROOT_W - 1)) begin
						state_q <= R_DIV;
					end
				end
				R_DIV: begin
					if (cnt_q == '0) begin
						done_q  <= 1'b1;
						state_q <= R_IDLE;
					end
				end
				default: state_q <= R_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			R_IDLE: begin
				dq_q   <= req.rad;
				rs_q   <= req.rs;
				rem_q  <= '0;
				root_q <= '0;
				cnt_q  <= '0;
			end
			R_SQRT: begin
				rem_q  <= rem_n;
				root_q <= root_n;
				dq_q   <= {dq_q[sds_pkg::RAD_W-3:0], 2'b00};
				if (cnt_q == 5'(sds_pkg::ROOT_W - 1)) begin
					s_q   <= root_n;
					q_q   <= '0;
					cnt_q <= 5'(sds_pkg::QUOT_W - 1);
				end else begin
					cnt_q <= cnt_q + 5'd1;
				end
			end
			R_DIV: begin
				s_q   <= s_n;
				q_q   <= q_n;
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == '0) begin
					v_q <= v_n;
				end
			end
			default: begin
				cnt_q <= '0;
			end
		endcase
	end

	assign resp.done = done_q;
	assign resp.v    = v_q;

endmodule

// File: tb/testbench.sv
// Self-checking testbench for soft_disk_min_stamp: directed and random reveals and reads.
// Depends on sds_pkg and the RTL of the block; keeps its own model of the coverage map.
`timescale 1ns / 1ps
module testbench;

	localparam int   MAP_SIZE       = sds_pkg::MAP_SIZE;
	localparam int   STAMP_BASE     = sds_pkg::STAMP_BASE;
	localparam int   STAMP_K        = sds_pkg::STAMP_K;
	localparam int   RS_W           = sds_pkg::RS_W;
	localparam int   WATCHDOG_LIMIT = 1000000;
	localparam int   DRAIN_CYCLES   = 60;
	localparam longint INT32_MIN = -64'sd2147483648;
	localparam longint INT32_MAX = 64'sd2147483647;
	localparam int   TEX_SHIFT      = 16;
	localparam longint CENTER_OFS   = MAP_SIZE * 128;

	typedef enum logic {ACT_REVEAL = 1'b0, ACT_READ = 1'b1} action_t;

	typedef struct packed {
		logic       changed;
		logic [7:0] box_x;
		logic [7:0] box_y;
		logic [8:0] box_width;
		logic [8:0] box_height;
		logic [7:0] pixel_value;
	} stamp_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy, done;
	logic cfg_we = 1'b0;
	logic [sds_pkg::CFG_IW-1:0] cfg_index = sds_pkg::REG_ORIGIN_X;
	logic [31:0] cfg_data = '0;
	logic action = ACT_REVEAL;
	logic signed [31:0] center_x = '0;
	logic signed [31:0] center_y = '0;
	logic [30:0] world_radius = '0;
	logic [7:0] read_x = '0;
	logic [7:0] read_y = '0;
	logic changed;
	logic [7:0] box_x, box_y, pixel_value;
	logic [8:0] box_width, box_height;

	soft_disk_min_stamp DUT (.*);

	always #10 clk = ~clk;

	// model state
	logic [7:0] fog_map [0:MAP_SIZE*MAP_SIZE-1];
	longint mdl_origin_x = 0;
	longint mdl_origin_y = 0;
	longint mdl_texels = 16777;

	stamp_result_t pending_q[$];
	int mismatches = 0;
	int reveals_sent = 0;
	int reads_sent = 0;
	int changed_seen = 0;
	int idle_cycles = 0;

	function automatic longint clamp_cell(longint v);
		if (v < 0)
			return 0;
		return ((v >> 8) > MAP_SIZE - 1) ? MAP_SIZE - 1 : (v >> 8);
	endfunction

	function automatic bit stamp_fits(longint unsigned n, longint unsigned r,
			longint unsigned dd);
		longint unsigned a;
		a = (n + STAMP_BASE) * r;
		return a * a <= longint'(STAMP_K) * dd;
	endfunction

	function automatic stamp_result_t stamp_disk(logic signed [31:0] cx_in,
			logic signed [31:0] cy_in, logic [30:0] rad);
		stamp_result_t res;
		longint tx, ty, x0, x1, y0, y1, sx, sy;
		longint unsigned rt, rs, ax, ay, dd, lo, hi, mid, v;
		int k;
		bit dirty;
		res = '0;
		dirty = 0;
		k = 0;
		tx = (((longint'(cx_in) - mdl_origin_x) * mdl_texels) >>> TEX_SHIFT) + CENTER_OFS;
		ty = (((longint'(cy_in) - mdl_origin_y) * mdl_texels) >>> TEX_SHIFT) + CENTER_OFS;
		rt = (longint'(rad) * mdl_texels) >> TEX_SHIFT;
		x0 = clamp_cell(tx - longint'(rt));
		x1 = clamp_cell(tx + longint'(rt));
		y0 = clamp_cell(ty - longint'(rt));
		y1 = clamp_cell(ty + longint'(rt));
		while ((rt >> k) >= (64'd1 << RS_W))
			k++;
		rs = rt >> k;
		for (longint x = x0; x <= x1; x++) begin
			for (longint y = y0; y <= y1; y++) begin
				sx = x * 256 - tx;
				sy = y * 256 - ty;
				ax = (sx < 0) ? -sx : sx;
				ay = (sy < 0) ? -sy : sy;
				if (ax >= rt || ay >= rt)
					continue;
				ax = ax >> k;
				ay = ay >> k;
				dd = ax * ax + ay * ay;
				if (dd >= rs * rs)
					continue;
				v = 0;
				if (stamp_fits(0, rs, dd)) begin
					lo = 0;
					hi = 254;
					while (lo < hi) begin
						mid = (lo + hi + 1) >> 1;
						if (stamp_fits(mid, rs, dd))
							lo = mid;
						else
							hi = mid - 1;
					end
					v = lo;
				end
				if (v < fog_map[y * MAP_SIZE + x]) begin
					fog_map[y * MAP_SIZE + x] = v[7:0];
					dirty = 1;
				end
			end
		end
		if (dirty) begin
			res.changed = 1'b1;
			res.box_x = x0[7:0];
			res.box_y = y0[7:0];
			res.box_width = 9'(x1 - x0 + 1);
			res.box_height = 9'(y1 - y0 + 1);
		end
		return res;
	endfunction

	// Drive one item, wait for it to be taken, then queue its expected result.
	// start stays high; the caller lowers it in idle_gap or drain_results.
	task automatic send_item(action_t act, logic signed [31:0] cx, logic signed [31:0] cy,
			logic [30:0] rad, logic [7:0] rx, logic [7:0] ry);
		stamp_result_t res;
		action <= act;
		center_x <= cx;
		center_y <= cy;
		world_radius <= rad;
		read_x <= rx;
		read_y <= ry;
		start <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		if (act == ACT_READ) begin
			res = '0;
			res.pixel_value = fog_map[ry * MAP_SIZE + rx];
			reads_sent++;
		end else begin
			res = stamp_disk(cx, cy, rad);
			reveals_sent++;
		end
		pending_q.push_back(res);
	endtask

	task automatic idle_gap();
		int n;
		if ($urandom_range(0, 9) == 0)
			n = $urandom_range(20, 200);
		else if ($urandom_range(0, 2) == 0)
			n = 0;
		else
			n = $urandom_range(1, 3);
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic drain_results();
		start <= 1'b0;
		@(posedge clk);
		while (pending_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write all three registers back to back; only called with the block idle.
	task automatic set_config(longint ox, longint oy, longint tpu);
		cfg_we <= 1'b1;
		cfg_index <= sds_pkg::REG_ORIGIN_X;
		cfg_data <= ox[31:0];
		@(posedge clk);
		cfg_index <= sds_pkg::REG_ORIGIN_Y;
		cfg_data <= oy[31:0];
		@(posedge clk);
		cfg_index <= sds_pkg::REG_TEXELS;
		cfg_data <= {8'd0, tpu[23:0]};
		@(posedge clk);
		cfg_we <= 1'b0;
		mdl_origin_x = longint'(signed'(ox[31:0]));
		mdl_origin_y = longint'(signed'(oy[31:0]));
		mdl_texels = tpu[23:0];
	endtask

	function automatic longint clamp32(longint v);
		return (v < INT32_MIN) ? INT32_MIN : ((v > INT32_MAX) ? INT32_MAX : v);
	endfunction

	// Aim a reveal at a texel-space center and radius (Q.8) under the current scale.
	task automatic reveal_at(longint ttx, longint tty, longint trt);
		longint cx, cy, rad;
		cx = clamp32(mdl_origin_x + ((ttx - CENTER_OFS) * 65536) / mdl_texels);
		cy = clamp32(mdl_origin_y + ((tty - CENTER_OFS) * 65536) / mdl_texels);
		rad = (trt * 65536) / mdl_texels;
		if (rad > INT32_MAX)
			rad = INT32_MAX;
		send_item(ACT_REVEAL, cx[31:0], cy[31:0], rad[30:0], 8'd0, 8'd0);
	endtask

	task automatic test_cleared_reads();
		send_item(ACT_READ, 0, 0, 0, 8'd0, 8'd0);
		send_item(ACT_READ, 0, 0, 0, 8'd255, 8'd0);
		send_item(ACT_READ, 0, 0, 0, 8'd0, 8'd255);
		idle_gap();
		send_item(ACT_READ, -1, -1, 31'h7FFFFFFF, 8'd255, 8'd255);
	endtask

	task automatic test_directed_reveals();
		reveal_at(CENTER_OFS, CENTER_OFS, 4 * 256);
		send_item(ACT_READ, 0, 0, 0, 8'd128, 8'd128);
		send_item(ACT_READ, 0, 0, 0, 8'd131, 8'd128);
		// overlapping disk: keep the lower value per texel
		reveal_at(CENTER_OFS + 300, CENTER_OFS - 200, 5 * 256);
		send_item(ACT_READ, 0, 0, 0, 8'd130, 8'd127);
		// zero radius stamps nothing
		reveal_at(CENTER_OFS, CENTER_OFS, 0);
		// center off the map: box pinned to the edge
		reveal_at(-20 * 256, 100 * 256, 6 * 256);
		reveal_at(300 * 256, 300 * 256, 3 * 256);
		reveal_at(-128, -128, 2 * 256);
		send_item(ACT_READ, 0, 0, 0, 8'd0, 8'd0);
		// extreme fields, one with a huge radius
		send_item(ACT_REVEAL, 32'sh7FFFFFFF, 32'sh80000000, 31'h7FFFFFFF, 8'hFF, 8'hFF);
		send_item(ACT_REVEAL, 32'sh80000000, 32'sh7FFFFFFF, 31'd0, 8'd0, 8'd0);
		send_item(ACT_READ, 0, 0, 0, 8'd200, 8'd20);
		drain_results();
	endtask

	task automatic test_scale_extremes();
		// unit scale: huge texel radius forces the normalize shift
		set_config(0, 0, 65536);
		send_item(ACT_REVEAL, 32'(200 - (64'd1 << 21) - CENTER_OFS), 32'(-CENTER_OFS),
			31'(64'd1 << 21), 8'd0, 8'd0);
		send_item(ACT_READ, 0, 0, 0, 8'd0, 8'd50);
		drain_results();
		// tiny scale: texel radius rounds to zero
		set_config(0, 0, 1);
		send_item(ACT_REVEAL, 0, 0, 31'd65535, 8'd0, 8'd0);
		drain_results();
	endtask

	task automatic random_phase(longint ox, longint oy, longint tpu, int count);
		longint ttx, tty, trt;
		int pick;
		set_config(ox, oy, tpu);
		ttx = CENTER_OFS;
		tty = CENTER_OFS;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 72) begin
				ttx = longint'($urandom_range(0, 262 * 256)) - 3 * 256;
				tty = longint'($urandom_range(0, 262 * 256)) - 3 * 256;
				trt = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 10 * 256)
					: $urandom_range(0, 5 * 256);
				reveal_at(ttx, tty, trt);
			end else if (pick < 94) begin
				if ($urandom_range(0, 1) && ttx >= 0 && ttx < MAP_SIZE * 256 &&
						tty >= 0 && tty < MAP_SIZE * 256)
					send_item(ACT_READ, $urandom, $urandom, 31'($urandom),
						8'(ttx >> 8), 8'(tty >> 8));
				else
					send_item(ACT_READ, $urandom, $urandom, 31'($urandom),
						8'($urandom), 8'($urandom));
			end else begin
				// noise: any center, radius kept small so the box stays cheap
				send_item(ACT_REVEAL, $urandom, $urandom, 31'($urandom_range(0, 3)),
					8'($urandom), 8'($urandom));
			end
			idle_gap();
			if (i == count / 2)
				drain_results();
		end
		drain_results();
	endtask

	task automatic test_random();
		random_phase(0, 0, 16777, 50);
		random_phase(0, 0, 65536, 50);
		random_phase(longint'($urandom_range(0, 2000)) - 1000,
			longint'($urandom_range(0, 2000)) - 1000, 131072, 45);
		random_phase(INT32_MAX, INT32_MIN, 24'hFFFFFF, 40);
		random_phase(INT32_MIN, INT32_MAX, 1, 40);
		random_phase(longint'(signed'(32'($urandom))), longint'(signed'(32'($urandom))),
			$urandom_range(1000, 200000), 45);
	endtask

	// result checker
	always @(posedge clk) begin
		stamp_result_t got, want;
		if (arst_n && done) begin
			got = '{changed, box_x, box_y, box_width, box_height, pixel_value};
			if (pending_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat: %p", got);
			end else begin
				want = pending_q.pop_front();
				if (got.changed) changed_seen++;
				if (got.changed !== want.changed || got.box_x !== want.box_x ||
						got.box_y !== want.box_y || got.box_width !== want.box_width ||
						got.box_height !== want.box_height ||
						got.pixel_value !== want.pixel_value) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p, got %p", want, got);
				end
			end
		end
	end

	// watchdog: count cycles with no beat in either direction
	always @(posedge clk) begin
		if ((start && !busy) || done || cfg_we || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired with %0d results pending", pending_q.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < MAP_SIZE * MAP_SIZE; i++)
			fog_map[i] = 8'hFF;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_cleared_reads();
		test_directed_reveals();
		test_scale_extremes();
		test_random();
		drain_results();
		if (pending_q.size() != 0)
			mismatches++;
		$display("covered %0d reveals (%0d of them lowered texels) and %0d reads",
			reveals_sent, changed_seen, reads_sent);
		$display("over nine scale and origin settings, with off-map and huge-radius cases");
		if (mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
